/* sv/assert_macros.svh */
// assertion macros for the glyph quad layout rtl
// expects a clock named aclk and an active-low reset named aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GQL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define GQL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/gql_pkg.sv */
// shared types, constants and helper functions for the glyph quad layout block
// no dependencies
`default_nettype none

package gql_pkg;

    // glyph table
    localparam int GLYPH_CODES = 256;
    localparam int GLYPH_AW    = $clog2(GLYPH_CODES);

    // field widths
    localparam int POS_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 176;
    localparam int M_TDATA_W  = 208;

    // item operations
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_CHAR  = 2'd2
    } op_t;

    // what an item does once it reaches the pen stage
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_START,
        KIND_NEWLINE,
        KIND_MISSING,
        KIND_QUAD
    } kind_t;

    // special character codes
    localparam logic [15:0] CHAR_NEWLINE = 16'd10;
    localparam logic [15:0] CHAR_RETURN  = 16'd13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FONT_SIZE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TEX_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TEX_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR     = 3'd5;

    // register reset values
    localparam logic [11:0] RST_LINE_HEIGHT    = 12'd30;
    localparam logic [11:0] RST_FONT_SIZE      = 12'd24;
    localparam logic [15:0] RST_SCALE          = 16'd4096;
    localparam logic [23:0] RST_INV_TEX_WIDTH  = 24'd65536;
    localparam logic [23:0] RST_INV_TEX_HEIGHT = 24'd65536;
    localparam logic [31:0] RST_TEXT_COLOR     = 32'hFFFF_FFFF;

    // saturation bounds of a Q16.4 position
    localparam logic signed [22:0] POS_MAX = 23'sd524287;
    localparam logic signed [22:0] POS_MIN = -23'sd524288;

    // clamp a wide position sum into 20 bits
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [22:0] v);
        logic signed [POS_W-1:0] r;
        if (v > POS_MAX) begin
            r = 20'sh7FFFF;
        end else if (v < POS_MIN) begin
            r = 20'sh80000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    // round texels*inv from Q.24 to Q.16, clamp to 16 bits
    function automatic logic [15:0] tex_round(input logic [36:0] p);
        logic [28:0] r;
        r = 29'((p + 37'd128) >> 8);
        return (r[28:16] != 13'd0) ? 16'hFFFF : r[15:0];
    endfunction

endpackage

`default_nettype wire

/* sv/glyph_quad_layout.sv */
// glyph quad layout top level: glyph tables, scaling pipeline and pen state
// depends on gql_pkg and assert_macros.svh
//
// channel   dir  handshake              payload
// s_        in   s_tvalid / s_tready    s_tuser op, s_tdata glyph and start fields
// m_        out  m_tvalid / m_tready    m_tdata quad edges, uv, colour, vertex
// cfg_      in   cfg_valid / cfg_ready  cfg_index register, cfg_data value
//
// one item is taken per cycle while s_tready is high; a quad passes stages 1, 2
// and 3, then the output register (glyph memory read, multiply, round, pen add)
// the pen add in the last stage is the only loop from one item to the next
// reset is synchronous and clears the pipeline, pen, vertex count, registers
// and the glyph valid bits; the glyph memories themselves are not cleared
// a stalled output fills the stages behind it, then s_tready falls
`default_nettype none

`include "assert_macros.svh"

module glyph_quad_layout (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // item input
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // op [1:0]
    input  wire logic [1:0]                       s_tuser,
    // code, glyph_x, glyph_y, glyph_w, glyph_h, glyph_xoff, glyph_yoff,
    // glyph_advance, origin_x, origin_y, base_vertex, zero pad
    input  wire logic [gql_pkg::S_TDATA_W-1:0]    s_tdata,
    // quad output
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // screen_x0, screen_y0, screen_x1, screen_y1, tex_u0, tex_v0, tex_u1,
    // tex_v1, quad_color, first_vertex
    output logic [gql_pkg::M_TDATA_W-1:0]         m_tdata,
    // register writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [gql_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gql_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [11:0] line_height_reg;
    logic [11:0] font_size_reg;
    logic [15:0] scale_reg;
    logic [23:0] inv_w_reg;
    logic [23:0] inv_h_reg;
    logic [31:0] color_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_height_reg <= gql_pkg::RST_LINE_HEIGHT;
            font_size_reg   <= gql_pkg::RST_FONT_SIZE;
            scale_reg       <= gql_pkg::RST_SCALE;
            inv_w_reg       <= gql_pkg::RST_INV_TEX_WIDTH;
            inv_h_reg       <= gql_pkg::RST_INV_TEX_HEIGHT;
            color_reg       <= gql_pkg::RST_TEXT_COLOR;
        end else if (cfg_valid) begin
            case (cfg_index)
                gql_pkg::REG_LINE_HEIGHT:    line_height_reg <= cfg_data[11:0];
                gql_pkg::REG_FONT_SIZE:      font_size_reg   <= cfg_data[11:0];
                gql_pkg::REG_SCALE:          scale_reg       <= cfg_data[15:0];
                gql_pkg::REG_INV_TEX_WIDTH:  inv_w_reg       <= cfg_data[23:0];
                gql_pkg::REG_INV_TEX_HEIGHT: inv_h_reg       <= cfg_data[23:0];
                gql_pkg::REG_TEXT_COLOR:     color_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input unpacking
    // ------------------------------------------------------------------
    gql_pkg::op_t                   in_op;
    logic [15:0]                    in_code;
    logic [11:0]                    in_gx, in_gy, in_gw, in_gh, in_adv;
    logic [11:0]                    in_xoff, in_yoff;
    logic signed [gql_pkg::POS_W-1:0] in_ox, in_oy;
    logic [31:0]                    in_base;
    logic                           in_range;
    logic [gql_pkg::GLYPH_AW-1:0]   in_idx;
    logic                           s_acc;
    logic                           load_we;
    gql_pkg::kind_t                 in_kind;

    assign in_op   = gql_pkg::op_t'(s_tuser);
    assign in_code = s_tdata[15:0];
    assign in_gx   = s_tdata[27:16];
    assign in_gy   = s_tdata[39:28];
    assign in_gw   = s_tdata[51:40];
    assign in_gh   = s_tdata[63:52];
    assign in_xoff = s_tdata[75:64];
    assign in_yoff = s_tdata[87:76];
    assign in_adv  = s_tdata[99:88];
    assign in_ox   = $signed(s_tdata[119:100]);
    assign in_oy   = $signed(s_tdata[139:120]);
    assign in_base = s_tdata[171:140];

    // codes past the table count as never loaded
    assign in_range = {1'b0, in_code} < 17'(gql_pkg::GLYPH_CODES);
    assign in_idx   = in_code[gql_pkg::GLYPH_AW-1:0];

    assign s_acc   = s_tvalid && s_tready;
    assign load_we = s_acc && (in_op == gql_pkg::OP_LOAD) && in_range;

    // ------------------------------------------------------------------
    // glyph tables: rectangle and metrics memories, valid bits in flops
    // a load writes at its accept edge, a character reads at its own,
    // so a character right after a load of the same code sees the new entry
    // ------------------------------------------------------------------
    logic [47:0]                    rect_mem [gql_pkg::GLYPH_CODES];
    logic [35:0]                    met_mem  [gql_pkg::GLYPH_CODES];
    logic [gql_pkg::GLYPH_CODES-1:0] glyph_vld_reg;
    logic [47:0]                    rect_rd_reg;
    logic [35:0]                    met_rd_reg;

    always_ff @(posedge aclk) begin
        if (load_we) begin
            rect_mem[in_idx] <= {in_gh, in_gw, in_gy, in_gx};
            met_mem[in_idx]  <= {in_adv, in_yoff, in_xoff};
        end
        if (s_acc) begin
            rect_rd_reg <= rect_mem[in_idx];
            met_rd_reg  <= met_mem[in_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_vld_reg <= '0;
        end else if (load_we) begin
            glyph_vld_reg[in_idx] <= 1'b1;
        end
    end

    // classify the item while it is accepted
    always_comb begin
        in_kind = gql_pkg::KIND_NONE;
        case (in_op)
            gql_pkg::OP_START: begin
                in_kind = gql_pkg::KIND_START;
            end
            gql_pkg::OP_CHAR: begin
                if (in_code == gql_pkg::CHAR_NEWLINE) begin
                    in_kind = gql_pkg::KIND_NEWLINE;
                end else if (in_code == gql_pkg::CHAR_RETURN) begin
                    in_kind = gql_pkg::KIND_NONE;
                end else if (in_range && glyph_vld_reg[in_idx]) begin
                    in_kind = gql_pkg::KIND_QUAD;
                end else begin
                    in_kind = gql_pkg::KIND_MISSING;
                end
            end
            default: in_kind = gql_pkg::KIND_NONE;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline flow: each stage moves when the one after it frees up
    // ------------------------------------------------------------------
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg;
    gql_pkg::kind_t s1_kind_reg, s2_kind_reg, s3_kind_reg;
    logic m_tvalid_reg;
    logic go3, free3, free2, free1;
    logic out_load;

    // only a quad needs room in the output register
    assign go3   = s3_vld_reg && ((s3_kind_reg != gql_pkg::KIND_QUAD)
                                  || !m_tvalid_reg || m_tready);
    assign free3 = !s3_vld_reg || go3;
    assign free2 = !s2_vld_reg || free3;
    assign free1 = !s1_vld_reg || free2;
    assign s_tready = free1;
    assign out_load = go3 && (s3_kind_reg == gql_pkg::KIND_QUAD);

    // ------------------------------------------------------------------
    // stage 1: item fields and glyph memory data, products formed here
    // ------------------------------------------------------------------
    logic signed [gql_pkg::POS_W-1:0] s1_ox_reg, s1_oy_reg;
    logic [31:0]                      s1_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s1_kind_reg <= gql_pkg::KIND_NONE;
        end else if (s_acc) begin
            s1_vld_reg  <= 1'b1;
            s1_kind_reg <= in_kind;
        end else if (free2) begin
            s1_vld_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_ox_reg   <= in_ox;
            s1_oy_reg   <= in_oy;
            s1_base_reg <= in_base;
        end
    end

    logic [11:0]        s1_gx, s1_gy, s1_gw, s1_gh, s1_adv;
    logic signed [11:0] s1_xoff, s1_yoff;
    logic [12:0]        s1_gx_end, s1_gy_end;
    logic [11:0]        s1_inc_op;
    logic signed [28:0] s1_xoff_p, s1_yoff_p;
    logic [27:0]        s1_w_p, s1_h_p, s1_inc_p;
    logic [36:0]        s1_u0_p, s1_v0_p, s1_u1_p, s1_v1_p;

    assign s1_gx   = rect_rd_reg[11:0];
    assign s1_gy   = rect_rd_reg[23:12];
    assign s1_gw   = rect_rd_reg[35:24];
    assign s1_gh   = rect_rd_reg[47:36];
    assign s1_xoff = $signed(met_rd_reg[11:0]);
    assign s1_yoff = $signed(met_rd_reg[23:12]);
    assign s1_adv  = met_rd_reg[35:24];

    assign s1_gx_end = 13'(s1_gx) + 13'(s1_gw);
    assign s1_gy_end = 13'(s1_gy) + 13'(s1_gh);

    // one shared multiplier for whatever moves the pen
    always_comb begin
        case (s1_kind_reg)
            gql_pkg::KIND_MISSING: s1_inc_op = font_size_reg;
            gql_pkg::KIND_NEWLINE: s1_inc_op = line_height_reg;
            default:               s1_inc_op = s1_adv;
        endcase
    end

    assign s1_xoff_p = s1_xoff * $signed({1'b0, scale_reg});
    assign s1_yoff_p = s1_yoff * $signed({1'b0, scale_reg});
    assign s1_w_p    = s1_gw * scale_reg;
    assign s1_h_p    = s1_gh * scale_reg;
    assign s1_inc_p  = s1_inc_op * scale_reg;
    assign s1_u0_p   = s1_gx * inv_w_reg;
    assign s1_v0_p   = s1_gy * inv_h_reg;
    assign s1_u1_p   = s1_gx_end * inv_w_reg;
    assign s1_v1_p   = s1_gy_end * inv_h_reg;

    // ------------------------------------------------------------------
    // stage 2: raw products, rounded here
    // ------------------------------------------------------------------
    logic signed [gql_pkg::POS_W-1:0] s2_ox_reg, s2_oy_reg;
    logic [31:0]                      s2_base_reg;
    logic signed [28:0]               s2_xoff_p_reg, s2_yoff_p_reg;
    logic [27:0]                      s2_w_p_reg, s2_h_p_reg, s2_inc_p_reg;
    logic [36:0]                      s2_u0_p_reg, s2_v0_p_reg, s2_u1_p_reg, s2_v1_p_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg  <= 1'b0;
            s2_kind_reg <= gql_pkg::KIND_NONE;
        end else if (free2) begin
            s2_vld_reg  <= s1_vld_reg;
            s2_kind_reg <= s1_kind_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (free2) begin
            s2_ox_reg     <= s1_ox_reg;
            s2_oy_reg     <= s1_oy_reg;
            s2_base_reg   <= s1_base_reg;
            s2_xoff_p_reg <= s1_xoff_p;
            s2_yoff_p_reg <= s1_yoff_p;
            s2_w_p_reg    <= s1_w_p;
            s2_h_p_reg    <= s1_h_p;
            s2_inc_p_reg  <= s1_inc_p;
            s2_u0_p_reg   <= s1_u0_p;
            s2_v0_p_reg   <= s1_v0_p;
            s2_u1_p_reg   <= s1_u1_p;
            s2_v1_p_reg   <= s1_v1_p;
        end
    end

    logic signed [20:0] s2_xs, s2_ys;
    logic [19:0]        s2_ws, s2_hs, s2_inc;
    logic signed [21:0] s2_xw, s2_yh;

    // Q.12 to Q.4, round half up, floor also for negative offsets
    assign s2_xs = 21'((s2_xoff_p_reg + 29'sd128) >>> 8);
    assign s2_ys = 21'((s2_yoff_p_reg + 29'sd128) >>> 8);
    assign s2_ws = 20'((s2_w_p_reg + 28'd128) >> 8);
    assign s2_hs = 20'((s2_h_p_reg + 28'd128) >> 8);
    // far edge offset relative to the pen
    assign s2_xw = 22'(s2_xs) + $signed({2'b00, s2_ws});
    assign s2_yh = 22'(s2_ys) + $signed({2'b00, s2_hs});

    // missing glyph advances by half the font size
    always_comb begin
        if (s2_kind_reg == gql_pkg::KIND_MISSING) begin
            s2_inc = 20'((s2_inc_p_reg + 28'd256) >> 9);
        end else begin
            s2_inc = 20'((s2_inc_p_reg + 28'd128) >> 8);
        end
    end

    // ------------------------------------------------------------------
    // stage 3: pen add, saturation, output register
    // ------------------------------------------------------------------
    logic signed [gql_pkg::POS_W-1:0] s3_ox_reg, s3_oy_reg;
    logic [31:0]                      s3_base_reg;
    logic signed [20:0]               s3_xs_reg, s3_ys_reg;
    logic signed [21:0]               s3_xw_reg, s3_yh_reg;
    logic [19:0]                      s3_inc_reg;
    logic [15:0]                      s3_u0_reg, s3_v0_reg, s3_u1_reg, s3_v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg  <= 1'b0;
            s3_kind_reg <= gql_pkg::KIND_NONE;
        end else if (free3) begin
            s3_vld_reg  <= s2_vld_reg;
            s3_kind_reg <= s2_kind_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (free3) begin
            s3_ox_reg   <= s2_ox_reg;
            s3_oy_reg   <= s2_oy_reg;
            s3_base_reg <= s2_base_reg;
            s3_xs_reg   <= s2_xs;
            s3_ys_reg   <= s2_ys;
            s3_xw_reg   <= s2_xw;
            s3_yh_reg   <= s2_yh;
            s3_inc_reg  <= s2_inc;
            s3_u0_reg   <= gql_pkg::tex_round(s2_u0_p_reg);
            s3_v0_reg   <= gql_pkg::tex_round(s2_v0_p_reg);
            s3_u1_reg   <= gql_pkg::tex_round(s2_u1_p_reg);
            s3_v1_reg   <= gql_pkg::tex_round(s2_v1_p_reg);
        end
    end

    // pen state, written only by the item leaving stage 3
    logic signed [gql_pkg::POS_W-1:0] pen_x_reg, pen_y_reg, line_x_reg;
    logic signed [gql_pkg::POS_W-1:0] pen_x_next, pen_y_next, line_x_next;
    logic [31:0]                      nv_reg, nv_next;

    logic signed [22:0] x0_w, y0_w, x1_w, y1_w, pen_x_inc, pen_y_inc;

    assign x0_w      = 23'(pen_x_reg) + 23'(s3_xs_reg);
    assign y0_w      = 23'(pen_y_reg) + 23'(s3_ys_reg);
    assign x1_w      = 23'(pen_x_reg) + 23'(s3_xw_reg);
    assign y1_w      = 23'(pen_y_reg) + 23'(s3_yh_reg);
    assign pen_x_inc = 23'(pen_x_reg) + $signed({3'b000, s3_inc_reg});
    assign pen_y_inc = 23'(pen_y_reg) + $signed({3'b000, s3_inc_reg});

    always_comb begin
        pen_x_next  = pen_x_reg;
        pen_y_next  = pen_y_reg;
        line_x_next = line_x_reg;
        nv_next     = nv_reg;
        if (go3) begin
            case (s3_kind_reg)
                gql_pkg::KIND_START: begin
                    pen_x_next  = s3_ox_reg;
                    pen_y_next  = s3_oy_reg;
                    line_x_next = s3_ox_reg;
                    nv_next     = s3_base_reg;
                end
                gql_pkg::KIND_NEWLINE: begin
                    pen_x_next = line_x_reg;
                    pen_y_next = gql_pkg::sat_pos(pen_y_inc);
                end
                gql_pkg::KIND_MISSING: begin
                    pen_x_next = gql_pkg::sat_pos(pen_x_inc);
                end
                gql_pkg::KIND_QUAD: begin
                    pen_x_next = gql_pkg::sat_pos(pen_x_inc);
                    nv_next    = nv_reg + 32'd4;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
            line_x_reg <= '0;
            nv_reg     <= '0;
        end else begin
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
            line_x_reg <= line_x_next;
            nv_reg     <= nv_next;
        end
    end

    // output register: holds a quad until it is taken
    logic                          m_tvalid_next;
    logic [gql_pkg::M_TDATA_W-1:0] m_tdata_reg;

    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {nv_reg, color_reg,
                            s3_v1_reg, s3_u1_reg, s3_v0_reg, s3_u0_reg,
                            gql_pkg::sat_pos(y1_w), gql_pkg::sat_pos(x1_w),
                            gql_pkg::sat_pos(y0_w), gql_pkg::sat_pos(x0_w)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // input stalls only once every stage and the output register are full
    `GQL_ASSERT_SAME(a_stall_only_when_full, !s_tready,
        s1_vld_reg && s2_vld_reg && s3_vld_reg && m_tvalid_reg,
        "input stalled with a bubble in the pipeline")
    // each quad that leaves moves the vertex count on by four
    `GQL_ASSERT_NEXT(a_vertex_step, out_load,
        nv_reg == $past(nv_reg) + 32'd4,
        "vertex count did not step by four after a quad")
    // a load marks its glyph as present from the next cycle
    `GQL_ASSERT_NEXT(a_load_sets_valid, load_we,
        glyph_vld_reg[$past(in_idx)],
        "glyph valid bit not set after a load")

endmodule

`default_nettype wire
